FILE: rtl/idalloc_pkg.sv
// Shared constants for the identifier allocator: field widths, request kinds,
// status codes and parameter defaults. Depends on nothing else.
package idalloc_pkg;

   localparam int ID_PORT_WIDTH = 10;
   localparam int STATUS_WIDTH  = 2;
   localparam int TDATA_WIDTH   = 16;

   localparam int DEFAULT_RECYCLE_DEPTH = 128;
   localparam int DEFAULT_ID_WIDTH      = 10;

   localparam logic FUNC_ALLOC   = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   localparam logic [STATUS_WIDTH-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_EXHAUSTED = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_FIFO_FULL = 2'd2;

endpackage

FILE: rtl/id_allocator_with_recycle_fifo.sv
// Identifier allocator with a recycle FIFO held in a synchronous memory.
// Depends on idalloc_pkg for widths, request kinds and status codes.
//
// Usage: each request on the req_ channel is either an allocate (tuser low)
// or a release of the identifier in tdata (tuser high). Every request yields
// exactly one response on the rsp_ channel, carrying the identifier handed
// out in tdata and a status in tuser (ok, no identifier left, FIFO full).
// A release, a fresh allocate or an exhausted allocate answers in the cycle
// after acceptance; an allocate served from the recycle FIFO first reads the
// FIFO head into the memory's read register and then loads it into the
// output register. Throughput is one request per cycle while the receiver
// takes responses; a FIFO-served allocate holds the input until its read returns.
// The response sits in an output register; a new request is taken while the
// current response is being taken in the same cycle. When the receiver
// stalls, the response holds and no further request is taken.
// Reset (synchronous) empties the FIFO and clears the fresh counter; the
// memory itself is not cleared, since the fill count guards every read.
module id_allocator_with_recycle_fifo
   import idalloc_pkg::*;
#(
   parameter int RECYCLE_DEPTH = DEFAULT_RECYCLE_DEPTH,
   parameter int ID_WIDTH      = DEFAULT_ID_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [TDATA_WIDTH-1:0] req_tdata,  // [9:0] release_id, rest zero
   input  logic                   req_tuser,  // [0] func
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [TDATA_WIDTH-1:0] rsp_tdata,  // [9:0] given_id, rest zero
   output logic [STATUS_WIDTH-1:0] rsp_tuser  // [1:0] status
);

   localparam int PTR_W = (RECYCLE_DEPTH > 1) ? $clog2(RECYCLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(RECYCLE_DEPTH + 1);
   localparam int EXT_W = (ID_WIDTH > ID_PORT_WIDTH) ? ID_WIDTH : ID_PORT_WIDTH;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RECYCLE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RECYCLE_DEPTH);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_READ = 1'b1;

   logic                    state_ff, state_in;
   logic [PTR_W-1:0]        head_ff, head_in;
   logic [PTR_W-1:0]        tail_ff, tail_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [ID_WIDTH:0]       fresh_ff, fresh_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ID_PORT_WIDTH-1:0] rsp_id_ff, rsp_id_in;
   logic [STATUS_WIDTH-1:0] rsp_status_ff, rsp_status_in;

   logic [ID_WIDTH-1:0]     ram [RECYCLE_DEPTH];
   logic [ID_WIDTH-1:0]     rd_data_ff;
   logic                    mem_we, mem_re;

   logic                    accept;
   logic [EXT_W-1:0]        rid_ext;
   logic [ID_WIDTH-1:0]     rid;
   logic [EXT_W-1:0]        fresh_ext;
   logic [EXT_W-1:0]        rd_ext;
   logic [ID_WIDTH:0]       last_issued;
   logic                    release_match;

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign rid_ext   = EXT_W'(req_tdata[ID_PORT_WIDTH-1:0]);
   assign rid       = rid_ext[ID_WIDTH-1:0];
   assign fresh_ext = EXT_W'(fresh_ff[ID_WIDTH-1:0]);
   assign rd_ext    = EXT_W'(rd_data_ff);

   // The last fresh identifier issued is one below the counter, if any.
   assign last_issued   = fresh_ff - (ID_WIDTH+1)'(1);
   assign release_match = (fresh_ff != '0) && ({1'b0, rid} == last_issued);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      fresh_in      = fresh_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;

      if (accept) begin
         if (req_tuser == FUNC_ALLOC) begin
            if (count_ff != '0) begin
               // Served from the FIFO: the response waits for the memory read.
               mem_re   = 1'b1;
               head_in  = (head_ff == PTR_LAST) ? '0 : head_ff + PTR_W'(1);
               count_in = count_ff - CNT_W'(1);
               state_in = S_READ;
            end else if (fresh_ff[ID_WIDTH]) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = '0;
               rsp_status_in = ST_EXHAUSTED;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = fresh_ext[ID_PORT_WIDTH-1:0];
               rsp_status_in = ST_OK;
               fresh_in      = fresh_ff + (ID_WIDTH+1)'(1);
            end
         end else begin
            rsp_valid_in = 1'b1;
            rsp_id_in    = '0;
            if (release_match) begin
               rsp_status_in = ST_OK;
               fresh_in      = last_issued;
            end else if (count_ff == CNT_FULL) begin
               rsp_status_in = ST_FIFO_FULL;
            end else begin
               rsp_status_in = ST_OK;
               mem_we        = 1'b1;
               tail_in       = (tail_ff == PTR_LAST) ? '0 : tail_ff + PTR_W'(1);
               count_in      = count_ff + CNT_W'(1);
            end
         end
      end

      if (state_ff == S_READ) begin
         rsp_valid_in  = 1'b1;
         rsp_id_in     = rd_ext[ID_PORT_WIDTH-1:0];
         rsp_status_in = ST_OK;
         state_in      = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ram[tail_ff] <= rid;
      end
      if (mem_re) begin
         rd_data_ff <= ram[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_WIDTH'(rsp_id_ff);
   assign rsp_tuser  = rsp_status_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("recycle count beyond FIFO depth");

   a_fresh_bound : assert property (@(posedge clock) disable iff (reset)
      !fresh_ff[ID_WIDTH] || (fresh_ff[ID_WIDTH-1:0] == '0))
      else $error("fresh counter beyond identifier range");

   a_read_slot_free : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> !rsp_valid_ff)
      else $error("output register busy while FIFO read returns");

   a_pop_count : assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == FUNC_ALLOC && count_ff != '0)
      |=> (count_ff == $past(count_ff) - CNT_W'(1)) && (state_ff == S_READ))
      else $error("FIFO pop did not update count and state");

endmodule
